[rtl/rme_pkg.sv]
// Shared types, constants and tables for the rotation-matrix to Euler-angle block.
// Used by rotation_matrix_to_euler, rme_cordic and rme_checker; depends on nothing.
package rme_pkg;

  // Field widths and fixed-point formats
  localparam int IN_W              = 16;
  localparam int ANG_W             = 16;
  localparam int IN_FRAC_BITS      = 14;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ANGLE_LIMIT       = 25736;

  // Square root: 32-bit radicand, one result bit per stage
  localparam int N_W     = 32;
  localparam int SY_W    = 16;
  localparam int SQ_STEPS = 16;

  // CORDIC datapath
  localparam int OPND_W = 17;
  localparam int CX_W   = 36;
  localparam int CZ_W   = 35;
  localparam logic signed [CZ_W-1:0] PI_Q30 = 35'sd3373259426;

  // Orthogonality check
  localparam int E_W    = 34;
  localparam int TERM_W = 41;
  localparam logic [TERM_W-1:0] TERM_SAT = 41'h100_0000_0000;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int THR_W      = 15;
  localparam int TOL_W      = 32;
  localparam logic [CFG_IDX_W-1:0] REG_SINGULAR_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORTHO_TOL          = 2'd1;

  typedef struct packed {
    logic signed [IN_W-1:0] r00;
    logic signed [IN_W-1:0] r01;
    logic signed [IN_W-1:0] r02;
    logic signed [IN_W-1:0] r10;
    logic signed [IN_W-1:0] r11;
    logic signed [IN_W-1:0] r12;
    logic signed [IN_W-1:0] r20;
    logic signed [IN_W-1:0] r21;
    logic signed [IN_W-1:0] r22;
  } in_t;

  typedef struct packed {
    logic signed [ANG_W-1:0] angle_x;
    logic signed [ANG_W-1:0] angle_y;
    logic signed [ANG_W-1:0] angle_z;
    logic                    is_singular;
    logic                    is_rotation;
  } out_t;

  // Matrix entries the angle path still needs after the square root
  typedef struct packed {
    logic signed [IN_W-1:0] r00;
    logic signed [IN_W-1:0] r10;
    logic signed [IN_W-1:0] r20;
    logic signed [IN_W-1:0] r21;
    logic signed [IN_W-1:0] r22;
    logic signed [IN_W-1:0] r11;
    logic signed [IN_W-1:0] r12;
  } car_t;

  // Upper triangle of R^T R: pair p covers columns pair_i(p), pair_j(p)
  function automatic logic [1:0] pair_i(input logic [2:0] p);
    logic [1:0] r;
    unique case (p)
      3'd0, 3'd1, 3'd2: r = 2'd0;
      3'd3, 3'd4:       r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] pair_j(input logic [2:0] p);
    logic [1:0] r;
    unique case (p)
      3'd0:       r = 2'd0;
      3'd1, 3'd3: r = 2'd1;
      default:    r = 2'd2;
    endcase
    return r;
  endfunction

  // atan(2^-i) in Q30 radians
  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] r;
    unique case (i)
      5'd0:  r = 30'd843314857;
      5'd1:  r = 30'd497837829;
      5'd2:  r = 30'd263043837;
      5'd3:  r = 30'd133525159;
      5'd4:  r = 30'd67021687;
      5'd5:  r = 30'd33543516;
      5'd6:  r = 30'd16775851;
      5'd7:  r = 30'd8388437;
      5'd8:  r = 30'd4194283;
      5'd9:  r = 30'd2097149;
      5'd10: r = 30'd1048576;
      5'd11: r = 30'd524288;
      5'd12: r = 30'd262144;
      5'd13: r = 30'd131072;
      5'd14: r = 30'd65536;
      5'd15: r = 30'd32768;
      5'd16: r = 30'd16384;
      5'd17: r = 30'd8192;
      5'd18: r = 30'd4096;
      5'd19: r = 30'd2048;
      5'd20: r = 30'd1024;
      5'd21: r = 30'd512;
      5'd22: r = 30'd256;
      5'd23: r = 30'd128;
      5'd24: r = 30'd64;
      5'd25: r = 30'd32;
      5'd26: r = 30'd16;
      5'd27: r = 30'd8;
      5'd28: r = 30'd4;
      5'd29: r = 30'd2;
      5'd30: r = 30'd1;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

[rtl/rme_cordic.sv]
// Pipelined vectoring CORDIC atan2 with rounding to Q3.13 and clamping.
// Depends on rme_pkg; the pipeline advances when en is high.
module rme_cordic import rme_pkg::*; #(
  parameter int STAGES = CORDIC_STAGES_DEF
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [OPND_W-1:0] y_in,
  input  logic signed [OPND_W-1:0] x_in,
  output logic signed [ANG_W-1:0]  angle
);

  logic signed [CX_W-1:0] cx [0:STAGES];
  logic signed [CX_W-1:0] cy [0:STAGES];
  logic signed [CZ_W-1:0] cz [0:STAGES];
  logic                   cf [0:STAGES];

  logic                     neg;
  logic signed [OPND_W-1:0] xp;
  logic signed [OPND_W-1:0] yp;
  logic signed [CZ_W-1:0]   z0;

  // Fold the left half plane onto the right with a start angle of +-pi
  always_comb begin
    neg = x_in < 0;
    xp  = neg ? -x_in : x_in;
    yp  = neg ? -y_in : y_in;
    if (!neg) begin
      z0 = '0;
    end else if (y_in >= 0) begin
      z0 = PI_Q30;
    end else begin
      z0 = -PI_Q30;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx[0] <= CX_W'(signed'({xp, 16'b0}));
      cy[0] <= CX_W'(signed'({yp, 16'b0}));
      cz[0] <= z0;
      cf[0] <= (x_in == '0) && (y_in == '0);
    end
  end

  // Rotate towards the x axis, one micro-rotation per stage
  for (genvar g = 0; g < STAGES; g++) begin : g_it
    logic signed [CX_W-1:0] dx;
    logic signed [CX_W-1:0] dy;
    logic signed [CZ_W-1:0] da;
    assign dx = cy[g] >>> g;
    assign dy = cx[g] >>> g;
    assign da = signed'(CZ_W'(atan_q30(5'(g))));
    always_ff @(posedge clk) begin
      if (en) begin
        cf[g+1] <= cf[g];
        if (cy[g] > 0) begin
          cx[g+1] <= cx[g] + dx;
          cy[g+1] <= cy[g] - dy;
          cz[g+1] <= cz[g] + da;
        end else begin
          cx[g+1] <= cx[g] - dx;
          cy[g+1] <= cy[g] + dy;
          cz[g+1] <= cz[g] - da;
        end
      end
    end
  end

  logic signed [CZ_W-1:0] q;
  assign q = (cz[STAGES] + CZ_W'(65536)) >>> 17;

  // Round half up, clamp, force zero for a zero vector
  always_ff @(posedge clk) begin
    if (en) begin
      if (cf[STAGES]) begin
        angle <= '0;
      end else if (q > CZ_W'(ANGLE_LIMIT)) begin
        angle <= ANG_W'(ANGLE_LIMIT);
      end else if (q < -CZ_W'(ANGLE_LIMIT)) begin
        angle <= -ANG_W'(ANGLE_LIMIT);
      end else begin
        angle <= ANG_W'(q);
      end
    end
  end

  // cx and cy only feed later stages; their last values are not needed
  logic unused_cx;
  assign unused_cx = ^cx[STAGES] ^ ^cy[STAGES];

endmodule

[rtl/rotation_matrix_to_euler.sv]
// One request per cycle while no finished result is stalled at the output.
// The depth is set by the 16-stage square root followed by the CORDIC pipeline.
// The whole pipeline holds while a finished result is stalled at the output.
// Reset (rst, synchronous) clears all valid bits and loads the singular threshold and
// orthogonality tolerance with 1. Depends on rme_pkg and rme_cordic.
module rotation_matrix_to_euler import rme_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_t                  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int LAT    = CORDIC_STAGES + 21;
  localparam int ROT_D  = CORDIC_STAGES + 14;
  localparam int SING_D = CORDIC_STAGES + 2;

  logic             advance;
  logic [LAT-1:0]   vld;
  logic [THR_W-1:0] thr;
  logic [TOL_W-1:0] tol;

  // Hold every stage while the result at the end is stalled
  assign advance  = !(vld[LAT-1] && out_stall);
  assign in_stall = !advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_W'(1);
      tol <= TOL_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_SINGULAR_THRESHOLD) begin
        thr <= cfg_data[THR_W-1:0];
      end else if (cfg_index == REG_ORTHO_TOL) begin
        tol <= cfg_data[TOL_W-1:0];
      end
    end
  end

  // Stage 1: register the request
  in_t s1;
  always_ff @(posedge clk) begin
    if (advance) begin
      s1 <= in_data;
    end
  end

  logic signed [IN_W-1:0] rm [0:2][0:2];
  always_comb begin
    rm[0][0] = s1.r00; rm[0][1] = s1.r01; rm[0][2] = s1.r02;
    rm[1][0] = s1.r10; rm[1][1] = s1.r11; rm[1][2] = s1.r12;
    rm[2][0] = s1.r20; rm[2][1] = s1.r21; rm[2][2] = s1.r22;
  end

  // Stage 2: products for R^T R; pair 0 also gives r00^2 and r10^2
  logic signed [2*IN_W-1:0] prod [0:5][0:2];
  car_t                     car2;
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int p = 0; p < 6; p++) begin
        for (int k = 0; k < 3; k++) begin
          prod[p][k] <= rm[k][pair_i(3'(p))] * rm[k][pair_j(3'(p))];
        end
      end
      car2 <= '{r00: s1.r00, r10: s1.r10, r20: s1.r20, r21: s1.r21,
                r22: s1.r22, r11: s1.r11, r12: s1.r12};
    end
  end

  // Stage 3: radicand and error entries E = I - R^T R
  logic signed [E_W-1:0] e3 [0:5];
  logic [16:0]           sq_rem  [0:SQ_STEPS];
  logic [SY_W-1:0]       sq_root [0:SQ_STEPS];
  logic [N_W-1:0]        sq_n    [0:SQ_STEPS];
  car_t                  sq_car  [0:SQ_STEPS];

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int p = 0; p < 6; p++) begin
        e3[p] <= ((pair_i(3'(p)) == pair_j(3'(p))) ? E_W'(1 << (2 * IN_FRAC_BITS)) : '0)
                 - E_W'(prod[p][0]) - E_W'(prod[p][1]) - E_W'(prod[p][2]);
      end
      sq_n[0]    <= N_W'(prod[0][0]) + N_W'(prod[0][1]);
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      sq_car[0]  <= car2;
    end
  end

  // Stages 4..19: digit-by-digit square root, two radicand bits per stage
  for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sq
    logic [18:0] cur;
    logic [18:0] trial;
    assign cur   = {sq_rem[g], sq_n[g][N_W-1 -: 2]};
    assign trial = 19'({sq_root[g], 2'b01});
    always_ff @(posedge clk) begin
      if (advance) begin
        sq_n[g+1]   <= sq_n[g] << 2;
        sq_car[g+1] <= sq_car[g];
        if (cur >= trial) begin
          sq_rem[g+1]  <= 17'(cur - trial);
          sq_root[g+1] <= {sq_root[g][SY_W-2:0], 1'b1};
        end else begin
          sq_rem[g+1]  <= 17'(cur);
          sq_root[g+1] <= {sq_root[g][SY_W-2:0], 1'b0};
        end
      end
    end
  end

  // Pick the atan2 operands once sy is known
  logic                     sing_c;
  logic signed [OPND_W-1:0] ax_y, ax_x, ay_y, ay_x, az_y, az_x;
  car_t                     cs;
  always_comb begin
    cs     = sq_car[SQ_STEPS];
    sing_c = sq_root[SQ_STEPS] < SY_W'(thr);
    ay_y   = -OPND_W'(cs.r20);
    ay_x   = signed'({1'b0, sq_root[SQ_STEPS]});
    az_y   = OPND_W'(cs.r10);
    az_x   = OPND_W'(cs.r00);
    if (sing_c) begin
      ax_y = -OPND_W'(cs.r12);
      ax_x = OPND_W'(cs.r11);
    end else begin
      ax_y = OPND_W'(cs.r21);
      ax_x = OPND_W'(cs.r22);
    end
  end

  logic signed [ANG_W-1:0] ang_x, ang_y, ang_z;

  rme_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_x (
    .clk(clk), .en(advance), .y_in(ax_y), .x_in(ax_x), .angle(ang_x)
  );
  rme_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_y (
    .clk(clk), .en(advance), .y_in(ay_y), .x_in(ay_x), .angle(ang_y)
  );
  rme_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_z (
    .clk(clk), .en(advance), .y_in(az_y), .x_in(az_x), .angle(ang_z)
  );

  // Carry the singular flag alongside the CORDIC pipelines
  logic [SING_D-1:0] sing_dly;
  always_ff @(posedge clk) begin
    if (advance) begin
      sing_dly <= {sing_dly[SING_D-2:0], sing_c};
    end
  end

  // Stage 4: split |e| into 16/17-bit halves and form partial products
  logic [31:0] pp_hh [0:5];
  logic [32:0] pp_hl [0:5];
  logic [33:0] pp_ll [0:5];
  logic [32:0] ea    [0:5];
  always_comb begin
    for (int p = 0; p < 6; p++) begin
      ea[p] = 33'((e3[p] < 0) ? -e3[p] : e3[p]);
    end
  end
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int p = 0; p < 6; p++) begin
        pp_hh[p] <= ea[p][32:17] * ea[p][32:17];
        pp_hl[p] <= ea[p][32:17] * ea[p][16:0];
        pp_ll[p] <= ea[p][16:0] * ea[p][16:0];
      end
    end
  end

  // Stage 5: combine, scale to Q13.28 and saturate each squared term
  logic [65:0]       sq66 [0:5];
  logic [65:0]       shq  [0:5];
  logic [TERM_W-1:0] term [0:5];
  always_comb begin
    for (int p = 0; p < 6; p++) begin
      sq66[p] = (66'(pp_hh[p]) << 34) + (66'(pp_hl[p]) << 18) + 66'(pp_ll[p]);
      shq[p]  = sq66[p] >> (2 * IN_FRAC_BITS);
    end
  end
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int p = 0; p < 6; p++) begin
        term[p] <= (shq[p] > 66'(TERM_SAT)) ? TERM_SAT : TERM_W'(shq[p]);
      end
    end
  end

  // Stage 6: diagonal and off-diagonal partial sums
  logic [TERM_W+1:0] dsum, osum;
  always_ff @(posedge clk) begin
    if (advance) begin
      dsum <= (TERM_W+2)'(term[0]) + (TERM_W+2)'(term[3]) + (TERM_W+2)'(term[5]);
      osum <= (TERM_W+2)'(term[1]) + (TERM_W+2)'(term[2]) + (TERM_W+2)'(term[4]);
    end
  end

  // Stage 7: off-diagonal terms appear twice; compare with the tolerance
  logic [TERM_W+2:0] total;
  logic              rot7;
  assign total = (TERM_W+3)'(dsum) + ((TERM_W+3)'(osum) << 1);
  always_ff @(posedge clk) begin
    if (advance) begin
      rot7 <= total < (TERM_W+3)'(tol);
    end
  end

  logic [ROT_D-1:0] rot_dly;
  always_ff @(posedge clk) begin
    if (advance) begin
      rot_dly <= {rot_dly[ROT_D-2:0], rot7};
    end
  end

  // Result
  assign out_valid            = vld[LAT-1];
  assign out_data.angle_x     = ang_x;
  assign out_data.angle_y     = ang_y;
  assign out_data.angle_z     = sing_dly[SING_D-1] ? '0 : ang_z;
  assign out_data.is_singular = sing_dly[SING_D-1];
  assign out_data.is_rotation = rot_dly[ROT_D-1];

  // Last radicand and remainder bits carry no information
  logic unused_sq;
  assign unused_sq = ^sq_n[SQ_STEPS] ^ ^sq_rem[SQ_STEPS];

endmodule

[rtl/rme_checker.sv]
// Port-level checks for rotation_matrix_to_euler, attached by the bind below.
// Depends on rme_pkg and the top level's port list.
module rme_checker import rme_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Input is held back only by a stalled result
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // Gimbal lock forces the z angle to zero
  a_sing_z: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.is_singular |-> out_data.angle_z == '0)
    else $error("angle_z non-zero on singular result");

  // The x and y angles stay within +-pi in Q3.13
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.angle_x <= ANGLE_LIMIT && out_data.angle_x >= -ANGLE_LIMIT
               && out_data.angle_y <= ANGLE_LIMIT && out_data.angle_y >= -ANGLE_LIMIT)
    else $error("angle out of range");

endmodule

bind rotation_matrix_to_euler rme_checker u_rme_checker (.*);
